FILE: hw/rtl/mcfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfq_pkg
// Shared types and codes for the multi-channel frame queue mux.
// ----------------------------------------------------------------------------
package mcfq_pkg;

  // command codes
  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_RECV   = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_SEND   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_CLRCNT = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // configuration register indexes
  localparam logic CFG_ATTACHED  = 1'b0;
  localparam logic CFG_RX_ENABLE = 1'b1;

  // most results one item may give
  localparam int unsigned MAX_RESULTS = 32;

  // per-channel frame build mode
  typedef enum logic [1:0] {
    BM_IDLE,
    BM_BUILD,
    BM_DROP,
    BM_REJECT
  } bmode_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NONE,
    S_SLEN,
    S_SBYTE,
    S_RREAD
  } state_t;

endpackage

FILE: hw/rtl/mcfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mcfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/multi_channel_frame_queue_mux_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_frame_queue_mux_unit
// Virtual channels over one link: per-channel frame transmit queues and
// receive byte rings held in RAM, round-robin frame send, drop counters.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  command  | start / busy        | in_cmd in_channel in_data in_frame_end
//           |                     | in_read_limit
//  result   | out_strobe          | out_status out_channel out_data out_valid
//           |                     | out_run_last out_tx_pending out_rx_pending
//           |                     | out_tx_drop_count out_rx_overflow_count
//  config   | cfg_we              | cfg_index cfg_wdata
//
// write, receive, clear, counter clear, empty or rejected read and unused
// commands show their result the cycle after and busy stays low, so one may
// follow every cycle.
// read does one ring RAM read per byte until the limit or the ring runs out.
// send scans one channel per cycle, up to CHANNELS channels capped at 8,
// then reads the frame length RAM, then one frame RAM read per byte; with
// nothing pending, state S_NONE after the full scan gives the empty answer.
// frame bytes and ring bytes share one data RAM, frame bytes at the bottom.
// reset is synchronous and clears all control state at once; no RAM sweep.
// results are shown for one cycle each; the receiver cannot stall.
module multi_channel_frame_queue_mux_unit
  import mcfq_pkg::*;
#(
  parameter int CHANNELS           = 8,
  parameter int FRAMES_PER_CHANNEL = 4,
  parameter int FRAME_BYTES        = 32,
  parameter int RX_RING_BYTES      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_channel,
  input  logic [7:0]  in_data,
  input  logic        in_frame_end,
  input  logic [5:0]  in_read_limit,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [2:0]  out_channel,
  output logic [7:0]  out_data,
  output logic        out_valid,
  output logic        out_run_last,
  output logic [2:0]  out_tx_pending,
  output logic [6:0]  out_rx_pending,
  output logic [15:0] out_tx_drop_count,
  output logic [15:0] out_rx_overflow_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int NCH   = (CHANNELS < 8) ? CHANNELS : 8;
  localparam int CW    = $clog2(NCH);
  localparam int FPC   = FRAMES_PER_CHANNEL;
  localparam int HW    = (FPC > 1) ? $clog2(FPC) : 1;
  localparam int TCW   = $clog2(FPC + 1);
  localparam int BLW   = $clog2(FRAME_BYTES + 1);
  localparam int RHW   = $clog2(RX_RING_BYTES);
  localparam int RCW   = $clog2(RX_RING_BYTES + 1);
  localparam int FL_D  = NCH * FPC;
  localparam int FL_AW = $clog2(FL_D);
  localparam int FS_D  = FL_D * FRAME_BYTES;
  localparam int FS_AW = $clog2(FS_D);
  localparam int RR_D  = NCH * RX_RING_BYTES;
  localparam int RR_AW = $clog2(RR_D);
  localparam int DM_D  = FS_D + RR_D;
  localparam int DM_AW = $clog2(DM_D);
  localparam int LCAP  = (FRAME_BYTES < MAX_RESULTS) ? FRAME_BYTES : MAX_RESULTS;

  // per-channel control state
  logic [HW-1:0]  tx_head_r [NCH];
  logic [HW-1:0]  tx_tail_r [NCH];
  logic [TCW-1:0] tx_cnt_r  [NCH];
  logic [BLW-1:0] bld_len_r [NCH];
  bmode_t         bld_mode_r[NCH];
  logic [RHW-1:0] rx_head_r [NCH];
  logic [RHW-1:0] rx_tail_r [NCH];
  logic [RCW-1:0] rx_cnt_r  [NCH];
  logic           rx_cut_r  [NCH];

  logic [7:0]     attached_r, rx_en_r;
  logic [15:0]    drops_r, drops_nxt, ovf_r, ovf_nxt;
  logic [CW-1:0]  cursor_r, cursor_nxt;

  // sequencer registers
  state_t         state_r, state_nxt;
  logic [CW-1:0]  cur_r, cur_nxt;
  logic [CW-1:0]  steps_r, steps_nxt;
  logic [5:0]     rem_r, rem_nxt;
  logic [BLW-1:0] idx_r, idx_nxt, len_r, len_nxt;
  logic [FL_AW-1:0] slot_r, slot_nxt;

  // selected channel view and its next values
  logic [CW-1:0]  sel;
  logic [NCH-1:0] att_v, rxen_v;
  logic           att_s, rxen_s, ok_in, acc;
  logic [HW-1:0]  nx_th, nx_tt;
  logic [TCW-1:0] nx_tc;
  logic [BLW-1:0] nx_bl;
  bmode_t         nx_bm;
  logic [RHW-1:0] nx_rh, nx_rt;
  logic [RCW-1:0] nx_rc;
  logic           nx_cut, chan_we;

  // RAM ports
  logic             fs_we, fl_we, rr_we;
  logic [FS_AW-1:0] fs_wa, fs_ra;
  logic [FL_AW-1:0] fl_wa, fl_ra;
  logic [RR_AW-1:0] rr_wa, rr_ra;
  logic [7:0]       fs_wd, dm_q;
  logic             dm_we;
  logic [DM_AW-1:0] dm_wa, dm_ra;
  logic [BLW-1:0]   fl_wd, fl_q;

  // emit fields
  logic        em, em_ok, em_ram, em_last;
  logic [1:0]  em_st;
  logic [2:0]  em_ch;
  logic [31:0] txp_w, rxp_w;

  // output registers
  logic        strobe_r, from_ram_r, last_r;
  logic [1:0]  status_r;
  logic [2:0]  ch_r, txp_r;
  logic [6:0]  rxp_r;

  // conditions
  logic [5:0]     lim_c;
  logic [BLW-1:0] lenc;
  logic           rd_go, sd_go, scan_hit, scan_end;

  assign busy   = (state_r != S_IDLE);
  assign acc    = start && !busy;
  assign sel    = (state_r == S_IDLE) ? in_channel[CW-1:0] : cur_r;
  assign ok_in  = ({1'b0, in_channel} < 4'(NCH));
  assign att_v  = attached_r[NCH-1:0];
  assign rxen_v = rx_en_r[NCH-1:0];
  assign att_s  = att_v[sel];
  assign rxen_s = rxen_v[sel];
  assign lim_c  = (in_read_limit > 6'(MAX_RESULTS)) ? 6'(MAX_RESULTS) : in_read_limit;
  assign lenc   = (fl_q > BLW'(LCAP)) ? BLW'(LCAP) : fl_q;

  assign rd_go    = acc && (in_cmd == CMD_READ) && ok_in && att_s &&
                    (lim_c != 6'd0) && (rx_cnt_r[sel] != '0);
  assign sd_go    = acc && (in_cmd == CMD_SEND);
  assign scan_hit = att_s && (tx_cnt_r[sel] != '0);
  assign scan_end = (steps_r == CW'(NCH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (rd_go) begin
          state_nxt = S_RREAD;
        end else if (sd_go) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_SLEN;
        end else if (scan_end) begin
          state_nxt = S_NONE;
        end
      end
      S_NONE:  state_nxt = S_IDLE;
      S_SLEN:  state_nxt = (lenc == '0) ? S_IDLE : S_SBYTE;
      S_SBYTE: begin
        if (idx_r == len_r - BLW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RREAD: begin
        if (rem_r == 6'd1 || rx_cnt_r[sel] == RCW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory access and result fields
  always_comb begin
    bmode_t         md;
    logic [BLW-1:0] blc;
    logic [FL_AW-1:0] slot_w;

    nx_th  = tx_head_r[sel];
    nx_tt  = tx_tail_r[sel];
    nx_tc  = tx_cnt_r[sel];
    nx_bl  = bld_len_r[sel];
    nx_bm  = bld_mode_r[sel];
    nx_rh  = rx_head_r[sel];
    nx_rt  = rx_tail_r[sel];
    nx_rc  = rx_cnt_r[sel];
    nx_cut = rx_cut_r[sel];
    chan_we = 1'b0;
    md  = bld_mode_r[sel];
    blc = bld_len_r[sel];
    slot_w = FL_AW'(FL_AW'(sel) * FL_AW'(FPC) + FL_AW'(tx_head_r[sel]));

    fs_we = 1'b0;
    fs_wa = FS_AW'(FS_AW'(slot_w) * FS_AW'(FRAME_BYTES) + FS_AW'(blc));
    fs_wd = in_data;
    fs_ra = FS_AW'(FS_AW'(slot_r) * FS_AW'(FRAME_BYTES) + FS_AW'(idx_r));
    fl_we = 1'b0;
    fl_wa = slot_w;
    fl_wd = blc;
    fl_ra = FL_AW'(FL_AW'(sel) * FL_AW'(FPC) + FL_AW'(tx_tail_r[sel]));
    rr_we = 1'b0;
    rr_wa = RR_AW'(RR_AW'(sel) * RR_AW'(RX_RING_BYTES) + RR_AW'(rx_head_r[sel]));
    rr_ra = RR_AW'(RR_AW'(sel) * RR_AW'(RX_RING_BYTES) + RR_AW'(rx_tail_r[sel]));

    drops_nxt  = drops_r;
    ovf_nxt    = ovf_r;
    cursor_nxt = cursor_r;
    cur_nxt    = cur_r;
    steps_nxt  = steps_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    slot_nxt   = slot_r;

    em      = 1'b0;
    em_ok   = 1'b1;
    em_ram  = 1'b0;
    em_last = 1'b1;
    em_st   = ST_OK;
    em_ch   = 3'(sel);

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          em    = 1'b1;
          em_ok = ok_in;
          em_ch = in_channel;
          em_st = ST_REJECT;
          case (in_cmd)
            CMD_WRITE: begin
              if (ok_in && att_s) begin
                chan_we = 1'b1;
                // open a new frame, then check its length
                if (md == BM_IDLE) begin
                  md  = (tx_cnt_r[sel] >= TCW'(FPC)) ? BM_DROP : BM_BUILD;
                  blc = '0;
                end
                if (md != BM_REJECT && blc >= BLW'(FRAME_BYTES)) begin
                  md = BM_REJECT;
                end
                fs_wa = FS_AW'(FS_AW'(slot_w) * FS_AW'(FRAME_BYTES) + FS_AW'(blc));
                if (md == BM_BUILD) begin
                  fs_we = 1'b1;
                  blc   = blc + BLW'(1);
                  em_st = ST_OK;
                end else if (md == BM_DROP) begin
                  blc   = blc + BLW'(1);
                  em_st = ST_DROP;
                end
                fl_wd = blc;
                // commit or account on the last byte
                if (in_frame_end) begin
                  if (md == BM_BUILD) begin
                    fl_we = 1'b1;
                    nx_th = (tx_head_r[sel] == HW'(FPC - 1)) ? '0
                                                            : tx_head_r[sel] + HW'(1);
                    nx_tc = tx_cnt_r[sel] + TCW'(1);
                  end else if (md == BM_DROP && drops_r != 16'hFFFF) begin
                    drops_nxt = drops_r + 16'd1;
                  end
                  md  = BM_IDLE;
                  blc = '0;
                end
                nx_bm = md;
                nx_bl = blc;
              end
            end
            CMD_RECV: begin
              if (ok_in && att_s && rxen_s) begin
                if (rx_cut_r[sel]) begin
                  em_st = ST_DROP;
                end else if (rx_cnt_r[sel] >= RCW'(RX_RING_BYTES)) begin
                  if (ovf_r != 16'hFFFF) begin
                    ovf_nxt = ovf_r + 16'd1;
                  end
                  nx_cut = 1'b1;
                  em_st  = ST_DROP;
                end else begin
                  rr_we = 1'b1;
                  nx_rh = (rx_head_r[sel] == RHW'(RX_RING_BYTES - 1)) ? '0
                                                                       : rx_head_r[sel] + RHW'(1);
                  nx_rc = rx_cnt_r[sel] + RCW'(1);
                  em_st = ST_OK;
                end
              end
              if (ok_in) begin
                chan_we = 1'b1;
                if (in_frame_end) begin
                  nx_cut = 1'b0;
                end
              end
            end
            CMD_READ: begin
              if (ok_in && att_s) begin
                if (lim_c == 6'd0 || rx_cnt_r[sel] == '0) begin
                  em_st = ST_EMPTY;
                end else begin
                  em      = 1'b0;
                  rem_nxt = lim_c;
                  cur_nxt = sel;
                end
              end
            end
            CMD_SEND: begin
              em        = 1'b0;
              cur_nxt   = cursor_r;
              steps_nxt = '0;
            end
            CMD_CLEAR: begin
              if (ok_in) begin
                chan_we = 1'b1;
                nx_th = '0; nx_tt = '0; nx_tc = '0; nx_bl = '0; nx_bm = BM_IDLE;
                nx_rh = '0; nx_rt = '0; nx_rc = '0; nx_cut = 1'b0;
                em_st = ST_OK;
              end
            end
            CMD_CLRCNT: begin
              drops_nxt = '0;
              ovf_nxt   = '0;
              em_st     = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one channel tried per cycle from the cursor
        if (scan_hit) begin
          chan_we    = 1'b1;
          slot_nxt   = fl_ra;
          nx_tt      = (tx_tail_r[sel] == HW'(FPC - 1)) ? '0 : tx_tail_r[sel] + HW'(1);
          nx_tc      = tx_cnt_r[sel] - TCW'(1);
          cursor_nxt = (cur_r == CW'(NCH - 1)) ? '0 : cur_r + CW'(1);
        end else if (scan_end) begin
          cur_nxt = '0;
        end else begin
          cur_nxt   = (cur_r == CW'(NCH - 1)) ? '0 : cur_r + CW'(1);
          steps_nxt = steps_r + CW'(1);
        end
      end
      S_NONE: begin
        em    = 1'b1;
        em_st = ST_EMPTY;
        em_ch = 3'd0;
      end
      S_SLEN: begin
        idx_nxt = '0;
        len_nxt = lenc;
        if (lenc == '0) begin
          em = 1'b1;
        end
      end
      S_SBYTE: begin
        em      = 1'b1;
        em_ram  = 1'b1;
        em_last = (idx_r == len_r - BLW'(1));
        idx_nxt = idx_r + BLW'(1);
      end
      S_RREAD: begin
        chan_we = 1'b1;
        nx_rt   = (rx_tail_r[sel] == RHW'(RX_RING_BYTES - 1)) ? '0 : rx_tail_r[sel] + RHW'(1);
        nx_rc   = rx_cnt_r[sel] - RCW'(1);
        rem_nxt = rem_r - 6'd1;
        em      = 1'b1;
        em_ram  = 1'b1;
        em_last = (rem_r == 6'd1) || (rx_cnt_r[sel] == RCW'(1));
      end
      default: ;
    endcase

    txp_w = em_ok ? 32'(nx_tc) : 32'd0;
    rxp_w = em_ok ? 32'(nx_rc) : 32'd0;
  end

  // shared data RAM: frame bytes low, ring bytes above
  assign dm_we = fs_we || rr_we;
  assign dm_wa = rr_we ? DM_AW'(FS_D) + DM_AW'(rr_wa) : DM_AW'(fs_wa);
  assign dm_ra = (state_r == S_RREAD) ? DM_AW'(FS_D) + DM_AW'(rr_ra) : DM_AW'(fs_ra);

  // configuration registers and per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= '0;
      rx_en_r    <= '0;
      for (int c = 0; c < NCH; c++) begin
        tx_head_r[c] <= '0; tx_tail_r[c] <= '0; tx_cnt_r[c] <= '0;
        bld_len_r[c] <= '0; bld_mode_r[c] <= BM_IDLE;
        rx_head_r[c] <= '0; rx_tail_r[c] <= '0; rx_cnt_r[c] <= '0;
        rx_cut_r[c]  <= 1'b0;
      end
    end else begin
      for (int c = 0; c < NCH; c++) begin
        if (cfg_we && cfg_index == CFG_ATTACHED && (attached_r[c] ^ cfg_wdata[c])) begin
          // attach change drops the channel's queues
          tx_head_r[c] <= '0; tx_tail_r[c] <= '0; tx_cnt_r[c] <= '0;
          bld_len_r[c] <= '0; bld_mode_r[c] <= BM_IDLE;
          rx_head_r[c] <= '0; rx_tail_r[c] <= '0; rx_cnt_r[c] <= '0;
          rx_cut_r[c]  <= 1'b0;
        end else if (chan_we && sel == CW'(c)) begin
          tx_head_r[c] <= nx_th; tx_tail_r[c] <= nx_tt; tx_cnt_r[c] <= nx_tc;
          bld_len_r[c] <= nx_bl; bld_mode_r[c] <= nx_bm;
          rx_head_r[c] <= nx_rh; rx_tail_r[c] <= nx_rt; rx_cnt_r[c] <= nx_rc;
          rx_cut_r[c]  <= nx_cut;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ATTACHED:  attached_r <= cfg_wdata;
          CFG_RX_ENABLE: rx_en_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      drops_r  <= '0;
      ovf_r    <= '0;
      cur_r    <= '0;
      steps_r  <= '0;
      rem_r    <= '0;
      idx_r    <= '0;
      len_r    <= '0;
      slot_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      drops_r  <= drops_nxt;
      ovf_r    <= ovf_nxt;
      cur_r    <= cur_nxt;
      steps_r  <= steps_nxt;
      rem_r    <= rem_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      slot_r   <= slot_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r   <= 1'b0;
      from_ram_r <= 1'b0;
    end else begin
      strobe_r   <= em;
      from_ram_r <= em && em_ram;
    end
  end

  always_ff @(posedge clk) begin
    last_r   <= em_last;
    status_r <= em_st;
    ch_r     <= em_ch;
    txp_r    <= txp_w[2:0];
    rxp_r    <= rxp_w[6:0];
  end

  // frame and ring bytes
  mcfq_ram #(.WIDTH(8), .DEPTH(DM_D)) u_data_ram (
    .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(fs_wd), .raddr(dm_ra), .rdata(dm_q)
  );

  // frame lengths
  mcfq_ram #(.WIDTH(BLW), .DEPTH(FL_D)) u_len_ram (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_q)
  );

  assign out_strobe            = strobe_r;
  assign out_status            = status_r;
  assign out_channel           = ch_r;
  assign out_data              = from_ram_r ? dm_q : 8'd0;
  assign out_valid             = from_ram_r;
  assign out_run_last          = last_r;
  assign out_tx_pending        = txp_r;
  assign out_rx_pending        = rxp_r;
  assign out_tx_drop_count     = drops_r;
  assign out_rx_overflow_count = ovf_r;

  // checks
  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_cmd != CMD_READ && in_cmd != CMD_SEND |=> out_strobe && out_run_last)
    else $error("single-cycle command gave no final result");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RREAD |-> rx_cnt_r[sel] != '0 && rem_r != 6'd0)
    else $error("ring read with nothing left");

  a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r[sel] <= TCW'(FPC))
    else $error("transmit queue count over depth");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_strobe && out_status == ST_OK)
    else $error("byte given without ok status");

  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> !out_strobe)
    else $error("result during channel scan");

endmodule
